// ----- sv/scc_pkg.sv -----
// Shared types and constants for the strongly connected components block.
`timescale 1ns / 1ps

package scc_pkg;

    localparam int NODES      = 64;
    localparam int MAX_DEGREE = 8;
    localparam int NODE_W     = 6;
    localparam int SLOT_W     = 3;
    localparam int DEG_W      = 4;
    localparam int NUM_W      = 7;
    localparam int ADJ_AW     = NODE_W + SLOT_W;

    typedef enum logic [1:0] {
        OP_DEGREE = 2'd0,
        OP_ADJ    = 2'd1,
        OP_RUN    = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [DEG_W-1:0]  edge_idx;
        logic [NUM_W-1:0]  disc;
        logic [NUM_W-1:0]  low;
        logic [DEG_W-1:0]  deg;
    } frame_t;

endpackage

// ----- sv/scc_ram.sv -----
// Simple dual-port synchronous RAM with registered read data.
`timescale 1ns / 1ps

module scc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- sv/strongly_connected_components.sv -----
// Top level: Tarjan strongly connected components engine over a stored graph.
//
// Input channel s_axis: tuser carries the op, tdata the node, slot, neighbor
// and degree. A clear keeps the graph. A run searches depth first from the
// root and sends one item on m_axis per node closed into a component (tdata:
// member and component number, tlast on the final item of the run). A run from
// an already visited root sends one item with tuser set and component zero.
// A run opens the root, then for each edge examined reads the adjacency slot
// and then the neighbor's visit state, opening the neighbor if unvisited; a
// node whose edge list is done compares its links, pops its component if it
// is the component root, and returns to its parent, if any, via a frame read.
// Each memory read is registered. The block takes no new item until the run ends.
// Reset clears degrees, visit state and counters at once through valid bits;
// adjacency slots are undefined until written. When m_axis stalls, the output
// register holds its item and the search waits at the next component item.
`timescale 1ns / 1ps

module strongly_connected_components (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // node, slot, neighbor, degree, zero pad
    input  logic [1:0]  s_axis_tuser,   // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // member, component, zero pad
    output logic        m_axis_tuser,   // already_visited
    output logic        m_axis_tlast    // last
);

    localparam int NW = scc_pkg::NODE_W;
    localparam int CW = scc_pkg::NUM_W;
    localparam int DW = scc_pkg::DEG_W;
    localparam int FW = $bits(scc_pkg::frame_t);

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_DEG_W = 10'b0000000010,
        ST_EDGE  = 10'b0000000100,
        ST_ADJ_W = 10'b0000001000,
        ST_LOOK  = 10'b0000010000,
        ST_CLOSE = 10'b0000100000,
        ST_POP   = 10'b0001000000,
        ST_POP_W = 10'b0010000000,
        ST_RET   = 10'b0100000000,
        ST_RET_W = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic [NW-1:0] in_node;
    logic [2:0]    in_slot;
    logic [NW-1:0] in_neighbor;
    logic [DW-1:0] in_degree;
    logic [1:0]    in_op;
    logic          in_fire;
    logic          out_free;

    logic [scc_pkg::NODES-1:0] deg_vld_reg, deg_vld_next;
    logic [scc_pkg::NODES-1:0] vis_vld_reg, vis_vld_next;
    logic [CW-1:0] sp_reg, sp_next;
    logic [CW-1:0] depth_reg, depth_next;
    logic [CW-1:0] num_reg, num_next;
    logic [CW-1:0] comp_reg, comp_next;
    logic          out_valid_reg, out_valid_next;

    logic [NW-1:0] top_node_reg;
    logic [DW-1:0] top_edge_reg;
    logic [CW-1:0] top_disc_reg;
    logic [CW-1:0] top_low_reg;
    logic [DW-1:0] top_deg_reg;
    logic [NW-1:0] w_reg;
    logic [NW-1:0] out_member_reg;
    logic [CW-1:0] out_comp_reg;
    logic          out_visited_reg;
    logic          out_last_reg;

    logic [CW-1:0] depth_m1;
    logic [CW-1:0] depth_m2;
    logic [CW-1:0] sp_m1;

    logic                  adj_we, adj_re;
    logic [scc_pkg::ADJ_AW-1:0] adj_waddr, adj_raddr;
    logic [NW-1:0]         adj_rdata;
    logic                  deg_we, deg_re;
    logic [NW-1:0]         deg_raddr;
    logic [DW-1:0]         deg_wdata, deg_rdata;
    logic                  disc_we, vis_re;
    logic [NW-1:0]         disc_waddr;
    logic [CW-1:0]         disc_rdata;
    logic                  ons_we;
    logic [NW-1:0]         ons_waddr;
    logic                  ons_wdata, ons_rdata;
    logic                  frm_we, frm_re;
    scc_pkg::frame_t       frm_wdata, frm_rdata;
    logic                  stk_we, stk_re;
    logic [NW-1:0]         stk_rdata;

    logic w_visited;
    logic pop_is_top;
    logic pop_last;

    assign in_op       = s_axis_tuser;
    assign in_node     = s_axis_tdata[5:0];
    assign in_slot     = s_axis_tdata[8:6];
    assign in_neighbor = s_axis_tdata[14:9];
    assign in_degree   = s_axis_tdata[18:15];

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && out_free;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign depth_m1 = depth_reg - 7'd1;
    assign depth_m2 = depth_reg - 7'd2;
    assign sp_m1    = sp_reg - 7'd1;

    assign w_visited  = vis_vld_reg[w_reg];
    assign pop_is_top = (stk_rdata == top_node_reg);
    assign pop_last   = pop_is_top && (depth_reg == 7'd1);

    // Graph memories
    assign adj_we    = in_fire && (in_op == scc_pkg::OP_ADJ);
    assign adj_waddr = {in_node, in_slot};
    assign adj_re    = (state_reg == ST_EDGE);
    assign adj_raddr = {top_node_reg, top_edge_reg[2:0]};

    assign deg_we    = in_fire && (in_op == scc_pkg::OP_DEGREE);
    assign deg_wdata = (in_degree > DW'(scc_pkg::MAX_DEGREE)) ?
                       DW'(scc_pkg::MAX_DEGREE) : in_degree;
    assign deg_re    = (state_reg == ST_IDLE) || (state_reg == ST_LOOK);
    assign deg_raddr = (state_reg == ST_LOOK) ? w_reg : in_node;

    // Visit-state memories
    logic root_open;
    logic push_w;
    assign root_open = in_fire && (in_op == scc_pkg::OP_RUN) && !vis_vld_reg[in_node];
    assign push_w    = (state_reg == ST_LOOK) && !w_visited;

    assign vis_re     = (state_reg == ST_ADJ_W);
    assign disc_we    = root_open || push_w;
    assign disc_waddr = root_open ? in_node : w_reg;

    assign ons_we    = root_open || push_w ||
                       ((state_reg == ST_POP_W) && out_free);
    assign ons_waddr = (state_reg == ST_POP_W) ? stk_rdata : disc_waddr;
    assign ons_wdata = (state_reg != ST_POP_W);

    // Call frames and component stack
    assign frm_we    = push_w;
    assign frm_wdata = '{node: top_node_reg, edge_idx: top_edge_reg,
                         disc: top_disc_reg, low: top_low_reg, deg: top_deg_reg};
    assign frm_re    = (state_reg == ST_RET) && (depth_reg != 7'd1);
    assign stk_we    = disc_we;
    assign stk_re    = (state_reg == ST_POP);

    scc_ram #(.WIDTH(NW), .DEPTH(scc_pkg::NODES * scc_pkg::MAX_DEGREE)) u_adj (
        .clk(clk), .we(adj_we), .waddr(adj_waddr), .wdata(in_neighbor),
        .re(adj_re), .raddr(adj_raddr), .rdata(adj_rdata)
    );

    scc_ram #(.WIDTH(DW), .DEPTH(scc_pkg::NODES)) u_deg (
        .clk(clk), .we(deg_we), .waddr(in_node), .wdata(deg_wdata),
        .re(deg_re), .raddr(deg_raddr), .rdata(deg_rdata)
    );

    scc_ram #(.WIDTH(CW), .DEPTH(scc_pkg::NODES)) u_disc (
        .clk(clk), .we(disc_we), .waddr(disc_waddr), .wdata(num_reg),
        .re(vis_re), .raddr(adj_rdata), .rdata(disc_rdata)
    );

    scc_ram #(.WIDTH(1), .DEPTH(scc_pkg::NODES)) u_ons (
        .clk(clk), .we(ons_we), .waddr(ons_waddr), .wdata(ons_wdata),
        .re(vis_re), .raddr(adj_rdata), .rdata(ons_rdata)
    );

    scc_ram #(.WIDTH(FW), .DEPTH(scc_pkg::NODES)) u_frm (
        .clk(clk), .we(frm_we), .waddr(depth_m1[NW-1:0]), .wdata(frm_wdata),
        .re(frm_re), .raddr(depth_m2[NW-1:0]), .rdata(frm_rdata)
    );

    scc_ram #(.WIDTH(NW), .DEPTH(scc_pkg::NODES)) u_stk (
        .clk(clk), .we(stk_we), .waddr(sp_reg[NW-1:0]), .wdata(disc_waddr),
        .re(stk_re), .raddr(sp_m1[NW-1:0]), .rdata(stk_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        deg_vld_next   = deg_vld_reg;
        vis_vld_next   = vis_vld_reg;
        sp_next        = sp_reg;
        depth_next     = depth_reg;
        num_next       = num_reg;
        comp_next      = comp_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        if (disc_we)
        begin
            vis_vld_next[disc_waddr] = 1'b1;
            sp_next  = sp_reg + 7'd1;
            num_next = num_reg + 7'd1;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (in_op)
                        scc_pkg::OP_DEGREE: deg_vld_next[in_node] = 1'b1;
                        scc_pkg::OP_ADJ:    ;
                        scc_pkg::OP_CLEAR:
                        begin
                            vis_vld_next = '0;
                            sp_next      = '0;
                            num_next     = 7'd1;
                            comp_next    = '0;
                        end
                        default:
                        begin
                            if (vis_vld_reg[in_node])
                            begin
                                out_valid_next = 1'b1;
                            end
                            else
                            begin
                                depth_next = 7'd1;
                                state_next = ST_DEG_W;
                            end
                        end
                    endcase
                end
            end
            ST_DEG_W: state_next = ST_EDGE;
            ST_EDGE:  state_next = (top_edge_reg < top_deg_reg) ? ST_ADJ_W : ST_CLOSE;
            ST_ADJ_W: state_next = ST_LOOK;
            ST_LOOK:
            begin
                if (!w_visited)
                begin
                    depth_next = depth_reg + 7'd1;
                    state_next = ST_DEG_W;
                end
                else
                begin
                    state_next = ST_EDGE;
                end
            end
            ST_CLOSE:
            begin
                if (top_low_reg == top_disc_reg)
                begin
                    comp_next  = comp_reg + 7'd1;
                    state_next = ST_POP;
                end
                else
                begin
                    state_next = ST_RET;
                end
            end
            ST_POP:
            begin
                sp_next    = sp_m1;
                state_next = ST_POP_W;
            end
            ST_POP_W:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = pop_is_top ? ST_RET : ST_POP;
                end
            end
            ST_RET:
            begin
                depth_next = depth_m1;
                state_next = (depth_reg == 7'd1) ? ST_IDLE : ST_RET_W;
            end
            ST_RET_W: state_next = ST_EDGE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            deg_vld_reg   <= '0;
            vis_vld_reg   <= '0;
            sp_reg        <= '0;
            depth_reg     <= '0;
            num_reg       <= 7'd1;
            comp_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            deg_vld_reg   <= deg_vld_next;
            vis_vld_reg   <= vis_vld_next;
            sp_reg        <= sp_next;
            depth_reg     <= depth_next;
            num_reg       <= num_next;
            comp_reg      <= comp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (root_open || push_w)
        begin
            top_node_reg <= disc_waddr;
            top_edge_reg <= '0;
            top_disc_reg <= num_reg;
            top_low_reg  <= num_reg;
        end
        if (in_fire && (in_op == scc_pkg::OP_RUN) && vis_vld_reg[in_node])
        begin
            out_member_reg  <= in_node;
            out_comp_reg    <= '0;
            out_visited_reg <= 1'b1;
            out_last_reg    <= 1'b1;
        end
        unique case (state_reg)
            ST_DEG_W: top_deg_reg <= deg_vld_reg[top_node_reg] ? deg_rdata : '0;
            ST_EDGE:  top_edge_reg <= top_edge_reg + 4'd1;
            ST_ADJ_W: w_reg <= adj_rdata;
            ST_LOOK:
            begin
                if (w_visited && ons_rdata && (disc_rdata < top_low_reg))
                begin
                    top_low_reg <= disc_rdata;
                end
            end
            ST_POP_W:
            begin
                if (out_free)
                begin
                    out_member_reg  <= stk_rdata;
                    out_comp_reg    <= comp_reg;
                    out_visited_reg <= 1'b0;
                    out_last_reg    <= pop_last;
                end
            end
            ST_RET_W:
            begin
                top_node_reg <= frm_rdata.node;
                top_edge_reg <= frm_rdata.edge_idx;
                top_disc_reg <= frm_rdata.disc;
                top_deg_reg  <= frm_rdata.deg;
                top_low_reg  <= (top_low_reg < frm_rdata.low) ? top_low_reg : frm_rdata.low;
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_comp_reg, out_member_reg};
    assign m_axis_tuser  = out_visited_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// ----- sv/scc_checker.sv -----
// Port-level assertions for the strongly connected components block.
`timescale 1ns / 1ps

module scc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [23:0] s_axis_tdata,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    logic load_fire;
    assign load_fire = s_axis_tvalid && s_axis_tready &&
                       (s_axis_tuser != scc_pkg::OP_RUN) && (s_axis_tdata[23] == 1'b0);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output item changed while stalled");

    a_reject: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata[12:6] == 7'd0))
        else $error("rejected run item malformed");

    a_comp_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata[12:6] != 7'd0))
        else $error("component item with number zero");

    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        load_fire && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("load or clear item produced output");

endmodule

bind strongly_connected_components scc_checker u_scc_checker (.*);

// ----- verif/tb_top.sv -----
// Testbench for strongly_connected_components: stimulus table, random graphs, predictor.
`timescale 1ns / 1ps

module tb_top;

    localparam int IDLE_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 270;

    typedef struct {
        logic [5:0] member;
        logic [6:0] comp;
        bit         visited;
        bit         last;
    } scc_result_t;

    typedef struct {
        scc_pkg::op_t op;
        logic [5:0] node;
        logic [2:0] slot;
        logic [5:0] nb;
        logic [3:0] deg;
        bit         typed;
        logic [5:0] e_member;
        logic [6:0] e_comp;
        bit         e_visited;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    logic [5:0] adj_mem [scc_pkg::NODES*scc_pkg::MAX_DEGREE];
    logic [7:0] adj_written [scc_pkg::NODES];
    logic [3:0] out_deg [scc_pkg::NODES];
    logic [6:0] disc_num [scc_pkg::NODES];
    logic [6:0] low_link [scc_pkg::NODES];
    bit         on_stk [scc_pkg::NODES];
    logic [5:0] comp_stk [scc_pkg::NODES];
    int         comp_top;
    logic [5:0] frame_node [scc_pkg::NODES];
    logic [3:0] frame_edge [scc_pkg::NODES];
    logic [6:0] next_num;
    logic [6:0] comp_count;

    scc_result_t component_q[$];
    row_t        rows[$];
    int          errors = 0;
    int          items_sent = 0;
    int          idle_cycles = 0;
    bit          quiet_out = 1'b0;
    int          out_stall = 0;

    strongly_connected_components dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic report(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    task automatic clear_visits();
        for (int i = 0; i < scc_pkg::NODES; i++)
        begin
            disc_num[i] = '0;
            low_link[i] = '0;
            on_stk[i] = 1'b0;
        end
        comp_top = 0;
        next_num = 7'd1;
        comp_count = '0;
    endtask

    task automatic open_node(input logic [5:0] w, input int depth);
        disc_num[w] = next_num;
        low_link[w] = next_num;
        next_num++;
        if (comp_top < scc_pkg::NODES)
        begin
            comp_stk[comp_top] = w;
            comp_top++;
        end
        on_stk[w] = 1'b1;
        frame_node[depth] = w;
        frame_edge[depth] = '0;
    endtask

    task automatic search_components(input logic [5:0] root);
        int          depth;
        logic [5:0]  v;
        logic [5:0]  w;
        logic [5:0]  j;
        logic [3:0]  e;
        scc_result_t res;
        if (disc_num[root] != 0)
        begin
            res = '{member: root, comp: '0, visited: 1'b1, last: 1'b1};
            component_q.push_back(res);
            return;
        end
        open_node(root, 0);
        depth = 1;
        while (depth > 0)
        begin
            v = frame_node[depth-1];
            e = frame_edge[depth-1];
            if (e < out_deg[v])
            begin
                w = adj_mem[{v, e[2:0]}];
                frame_edge[depth-1] = e + 4'd1;
                if (disc_num[w] == 0)
                begin
                    if (depth < scc_pkg::NODES)
                    begin
                        open_node(w, depth);
                        depth++;
                    end
                end
                else if (on_stk[w] && disc_num[w] < low_link[v])
                    low_link[v] = disc_num[w];
            end
            else
            begin
                if (low_link[v] == disc_num[v])
                begin
                    comp_count++;
                    while (comp_top > 0)
                    begin
                        comp_top--;
                        j = comp_stk[comp_top];
                        on_stk[j] = 1'b0;
                        res = '{member: j, comp: comp_count, visited: 1'b0, last: 1'b0};
                        component_q.push_back(res);
                        if (j == v)
                            break;
                    end
                end
                depth--;
                if (depth > 0 && low_link[v] < low_link[frame_node[depth-1]])
                    low_link[frame_node[depth-1]] = low_link[v];
            end
        end
        res = component_q.pop_back();
        res.last = 1'b1;
        component_q.push_back(res);
    endtask

    task automatic apply_item(input scc_pkg::op_t op, input logic [5:0] node,
                              input logic [2:0] slot, input logic [5:0] nb,
                              input logic [3:0] deg);
        case (op)
            scc_pkg::OP_CLEAR:  clear_visits();
            scc_pkg::OP_DEGREE: out_deg[node] = (deg > scc_pkg::MAX_DEGREE) ?
                                                4'(scc_pkg::MAX_DEGREE) : deg;
            scc_pkg::OP_ADJ:    adj_mem[{node, slot}] = nb;
            default:            search_components(node);
        endcase
    endtask

    task automatic send_raw(input scc_pkg::op_t op, input logic [5:0] node,
                            input logic [2:0] slot, input logic [5:0] nb,
                            input logic [3:0] deg);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {5'd0, deg, nb, slot, node};
        if (op == scc_pkg::OP_ADJ)
            adj_written[node][slot] = 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
    endtask

    // write any unwritten slot below the new degree first
    task automatic send_item(input scc_pkg::op_t op, input logic [5:0] node,
                             input logic [2:0] slot, input logic [5:0] nb,
                             input logic [3:0] deg);
        int lim;
        if (op == scc_pkg::OP_DEGREE)
        begin
            lim = (deg > scc_pkg::MAX_DEGREE) ? scc_pkg::MAX_DEGREE : deg;
            for (int s = 0; s < lim; s++)
                if (!adj_written[node][s])
                begin
                    send_raw(scc_pkg::OP_ADJ, node, 3'(s), 6'($urandom_range(63)), 4'd0);
                    apply_item(scc_pkg::OP_ADJ, node, 3'(s), s_axis_tdata[14:9], 4'd0);
                end
        end
        send_raw(op, node, slot, nb, deg);
        apply_item(op, node, slot, nb, deg);
    endtask

    function automatic void add_row(input scc_pkg::op_t op, input logic [5:0] node,
                                    input logic [2:0] slot, input logic [5:0] nb,
                                    input logic [3:0] deg);
        rows.push_back('{op, node, slot, nb, deg, 1'b0, '0, '0, 1'b0});
    endfunction

    function automatic void add_typed_run(input logic [5:0] node, input logic [6:0] comp,
                                          input bit visited);
        rows.push_back('{scc_pkg::OP_RUN, node, '0, '0, '0, 1'b1, node, comp, visited});
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (quiet_out || out_stall == 0)
        begin
            m_axis_tready <= 1'b1;
            out_stall <= quiet_out ? 0 : pick_gap();
            if ($urandom_range(199) == 0)
                quiet_out <= !quiet_out;
        end
        else
        begin
            m_axis_tready <= 1'b0;
            out_stall <= out_stall - 1;
        end
    end

    always @(posedge clk)
    begin
        scc_result_t exp_res;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (component_q.size() == 0)
                report($sformatf("unexpected item member %0d", m_axis_tdata[5:0]));
            else
            begin
                exp_res = component_q.pop_front();
                if (m_axis_tdata[5:0] !== exp_res.member)
                    report($sformatf("member %0d, want %0d", m_axis_tdata[5:0], exp_res.member));
                if (m_axis_tdata[12:6] !== exp_res.comp)
                    report($sformatf("component %0d, want %0d", m_axis_tdata[12:6], exp_res.comp));
                if (m_axis_tdata[15:13] !== 3'd0)
                    report("nonzero pad bits");
                if (m_axis_tuser !== exp_res.visited)
                    report($sformatf("already_visited %b, want %b", m_axis_tuser, exp_res.visited));
                if (m_axis_tlast !== exp_res.last)
                    report($sformatf("last %b, want %b", m_axis_tlast, exp_res.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int          qn;
        int          k;
        int          base;
        int          d;
        int          r;
        logic [5:0]  n;
        row_t        rw;
        scc_result_t typed_res;

        for (int i = 0; i < scc_pkg::NODES; i++)
        begin
            out_deg[i] = '0;
            adj_written[i] = '0;
        end
        clear_visits();

        add_typed_run(6'd0, 7'd1, 1'b0);
        add_typed_run(6'd0, 7'd0, 1'b1);
        add_typed_run(6'd63, 7'd2, 1'b0);
        add_row(scc_pkg::OP_ADJ, 6'd5, 3'd0, 6'd6, 4'd0);
        add_row(scc_pkg::OP_ADJ, 6'd6, 3'd0, 6'd5, 4'd0);
        add_row(scc_pkg::OP_ADJ, 6'd6, 3'd1, 6'd63, 4'd0);
        add_row(scc_pkg::OP_DEGREE, 6'd5, 3'd0, 6'd0, 4'd1);
        add_row(scc_pkg::OP_DEGREE, 6'd6, 3'd0, 6'd0, 4'd2);
        add_row(scc_pkg::OP_RUN, 6'd5, 3'd0, 6'd0, 4'd0);
        add_typed_run(6'd6, 7'd0, 1'b1);
        add_row(scc_pkg::OP_CLEAR, 6'd63, 3'd7, 6'd63, 4'd15);
        for (int s = 0; s < scc_pkg::MAX_DEGREE; s++)
            add_row(scc_pkg::OP_ADJ, 6'd10, 3'(s), (s == 1) ? 6'd63 : 6'(s * 9 + 5), 4'd0);
        add_row(scc_pkg::OP_DEGREE, 6'd10, 3'd0, 6'd0, 4'd15);
        add_row(scc_pkg::OP_RUN, 6'd10, 3'd0, 6'd0, 4'd0);
        add_row(scc_pkg::OP_CLEAR, 6'd0, 3'd0, 6'd0, 4'd0);
        add_typed_run(6'd0, 7'd1, 1'b0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            rw = rows[i];
            if (rw.typed)
            begin
                send_raw(rw.op, rw.node, rw.slot, rw.nb, rw.deg);
                qn = component_q.size();
                apply_item(rw.op, rw.node, rw.slot, rw.nb, rw.deg);
                while (component_q.size() > qn)
                    void'(component_q.pop_back());
                typed_res = '{member: rw.e_member, comp: rw.e_comp,
                              visited: rw.e_visited, last: 1'b1};
                component_q.push_back(typed_res);
            end
            else
                send_item(rw.op, rw.node, rw.slot, rw.nb, rw.deg);
        end

        while (items_sent < RANDOM_ITEMS)
        begin
            r = $urandom_range(9);
            if (r < 7)
            begin
                if ($urandom_range(3) != 0)
                    send_item(scc_pkg::OP_CLEAR, 6'($urandom_range(63)),
                              3'($urandom_range(7)), 6'($urandom_range(63)),
                              4'($urandom_range(15)));
                k = $urandom_range(10, 2);
                base = $urandom_range(63);
                for (int i = 0; i < k; i++)
                begin
                    n = 6'((base + i) % scc_pkg::NODES);
                    d = ($urandom_range(9) == 0) ? $urandom_range(15, 8) : $urandom_range(3);
                    for (int s = 0; s < d && s < scc_pkg::MAX_DEGREE; s++)
                        send_item(scc_pkg::OP_ADJ, n, 3'(s),
                                  ($urandom_range(7) == 0) ? 6'($urandom_range(63))
                                                           : 6'((base + $urandom_range(k - 1))
                                                                % scc_pkg::NODES),
                                  4'($urandom_range(15)));
                    send_item(scc_pkg::OP_DEGREE, n, 3'($urandom_range(7)),
                              6'($urandom_range(63)), 4'(d));
                end
                repeat ($urandom_range(4, 1))
                    send_item(scc_pkg::OP_RUN,
                              6'((base + $urandom_range(k - 1)) % scc_pkg::NODES),
                              3'($urandom_range(7)), 6'($urandom_range(63)),
                              4'($urandom_range(15)));
            end
            else
                send_item(scc_pkg::op_t'($urandom_range(3)), 6'($urandom_range(63)),
                          3'($urandom_range(7)), 6'($urandom_range(63)),
                          4'($urandom_range(15)));
        end
        s_axis_tvalid <= 1'b0;

        while (component_q.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        if (errors == 0 && component_q.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

// ----- strongly_connected_components.f -----
sv/scc_pkg.sv
sv/scc_ram.sv
sv/strongly_connected_components.sv
sv/scc_checker.sv
verif/tb_top.sv
